// File: sv/ost_pkg.sv
package ost_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int NumExch    = 16;
  localparam int CntW       = 9;

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_UPDATE = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_LOOKUP = 3'd3;
  localparam logic [2:0] REQ_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] order_key;
    logic [2:0]  lifecycle_code;
    logic [3:0]  exchange_num;
    logic [63:0] exchange_ref;
    logic [63:0] filled_amount;
    logic [63:0] remaining_amount;
    logic [63:0] time_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  out_lifecycle;
    logic [3:0]  out_exchange;
    logic [63:0] out_exchange_ref;
    logic [63:0] out_filled;
    logic [63:0] out_remaining;
    logic [63:0] out_updated_at;
    logic [8:0]  exchange_open;
    logic [8:0]  total_open;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  lifecycle;
    logic [3:0]  exchange;
    logic [63:0] exchange_ref;
    logic [63:0] filled;
    logic [63:0] remaining;
    logic [63:0] updated_at;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic rd_rec;
    logic exec;
    logic count;
    logic report;
  } ost_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ost_sts_t;

  function automatic logic lc_open(input logic [2:0] lc);
    return lc <= 3'd2;
  endfunction

  function automatic logic exch_in_range(input logic [3:0] x);
    return {1'b0, x} < 5'(NumExch);
  endfunction

endpackage

// File: sv/ost_ctrl.sv
module ost_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ost_pkg::ost_sts_t sts,
  output ost_pkg::ost_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FLUSH, S_READ, S_EXEC, S_COUNT, S_REPORT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE:   if (start) state_r <= S_SCAN;
        S_SCAN:   if (sts.scan_last) state_r <= S_FLUSH;
        S_FLUSH:  state_r <= S_READ;
        S_READ:   state_r <= S_EXEC;
        S_EXEC:   state_r <= S_COUNT;
        S_COUNT:  state_r <= S_REPORT;
        S_REPORT: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == S_IDLE) && start;
    cmd.scan    = (state_r == S_SCAN);
    cmd.rd_rec  = (state_r == S_READ);
    cmd.exec    = (state_r == S_EXEC);
    cmd.count   = (state_r == S_COUNT);
    cmd.report  = (state_r == S_REPORT);
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REPORT |=> !busy) else $error("no return to idle after report");
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && sts.scan_last |=> state_r == S_FLUSH)
    else $error("scan did not end");

endmodule

// File: sv/ost_dp.sv
module ost_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ost_pkg::in_item_t   in_item,
  input  ost_pkg::ost_cmd_t   cmd,
  output ost_pkg::ost_sts_t   sts,
  output logic                out_valid,
  output ost_pkg::out_item_t  out_item
);

  localparam int IdxW = ost_pkg::IdxW;
  localparam int CntW = ost_pkg::CntW;

  ost_pkg::in_item_t  in_r;
  ost_pkg::rec_t      rec_mem [ost_pkg::TableDepth];
  logic [63:0]        key_mem [ost_pkg::TableDepth];
  logic               valid_r [ost_pkg::TableDepth];
  logic [CntW-1:0]    per_r   [ost_pkg::NumExch];
  logic [CntW-1:0]    total_r;

  logic [IdxW-1:0]    scan_r, idx_d_r, hit_idx_r, free_idx_r;
  logic               cmp_en_r, vld_d_r, hit_r, free_r;
  logic [63:0]        rdkey_r;
  ost_pkg::rec_t      rec_q_r;

  logic               chg_en_r, chg_up_r;
  logic [3:0]         chg_exch_r;
  logic [1:0]         status_r;
  ost_pkg::rec_t      lk_r;
  logic               out_valid_r;
  ost_pkg::out_item_t out_r;

  logic               match;
  logic               chg_en_nxt, chg_up_nxt, wr_en, wr_key, clr_valid;
  logic [3:0]         chg_exch_nxt;
  logic [1:0]         status_nxt;
  logic [IdxW-1:0]    wr_idx;
  ost_pkg::rec_t      wr_rec, lk_nxt;
  logic               rec_open, is_open;

  assign sts.scan_last = (scan_r == IdxW'(ost_pkg::TableDepth - 1));
  assign match = cmp_en_r && vld_d_r && (rdkey_r == in_r.order_key);

  always_comb begin
    chg_en_nxt   = 1'b0;
    chg_up_nxt   = 1'b0;
    chg_exch_nxt = rec_q_r.exchange;
    status_nxt   = ost_pkg::ST_OK;
    wr_en        = 1'b0;
    wr_key       = 1'b0;
    clr_valid    = 1'b0;
    wr_idx       = hit_idx_r;
    lk_nxt       = '0;
    rec_open     = ost_pkg::lc_open(rec_q_r.lifecycle);
    is_open      = ost_pkg::lc_open(in_r.lifecycle_code);
    wr_rec.lifecycle    = in_r.lifecycle_code;
    wr_rec.exchange     = in_r.exchange_num;
    wr_rec.exchange_ref = in_r.exchange_ref;
    wr_rec.filled       = in_r.filled_amount;
    wr_rec.remaining    = in_r.remaining_amount;
    wr_rec.updated_at   = in_r.time_ns;
    case (in_r.req_type)
      ost_pkg::REQ_INSERT: begin
        if (hit_r) begin
          status_nxt = ost_pkg::ST_DUP;
        end else if (!free_r) begin
          status_nxt = ost_pkg::ST_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_key       = 1'b1;
          wr_idx       = free_idx_r;
          chg_en_nxt   = is_open;
          chg_up_nxt   = 1'b1;
          chg_exch_nxt = in_r.exchange_num;
        end
      end
      ost_pkg::REQ_UPDATE: begin
        if (!hit_r) begin
          status_nxt = ost_pkg::ST_MISSING;
        end else begin
          wr_en           = 1'b1;
          wr_rec.exchange = rec_q_r.exchange;
          if (in_r.exchange_ref == 64'd0) wr_rec.exchange_ref = rec_q_r.exchange_ref;
          chg_en_nxt      = rec_open != is_open;
          chg_up_nxt      = is_open;
        end
      end
      ost_pkg::REQ_REMOVE: begin
        if (!hit_r) begin
          status_nxt = ost_pkg::ST_MISSING;
        end else begin
          clr_valid  = 1'b1;
          chg_en_nxt = rec_open;
        end
      end
      ost_pkg::REQ_LOOKUP: begin
        if (!hit_r) status_nxt = ost_pkg::ST_MISSING;
        else lk_nxt = rec_q_r;
      end
      default: ;
    endcase
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (cmd.scan) rdkey_r <= key_mem[scan_r];
    if (cmd.rd_rec) rec_q_r <= rec_mem[hit_idx_r];
    if (cmd.exec && wr_en) rec_mem[wr_idx] <= wr_rec;
    if (cmd.exec && wr_key) key_mem[wr_idx] <= in_r.order_key;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_item;
    if (cmd.scan) begin
      idx_d_r <= scan_r;
      vld_d_r <= valid_r[scan_r];
    end
    if (match && !hit_r) hit_idx_r <= idx_d_r;
    if (cmd.scan && !valid_r[scan_r] && !free_r) free_idx_r <= scan_r;
    if (cmd.exec) begin
      status_r   <= status_nxt;
      lk_r       <= lk_nxt;
      chg_up_r   <= chg_up_nxt;
      chg_exch_r <= chg_exch_nxt;
    end
    if (cmd.report) begin
      out_r.status           <= status_r;
      out_r.out_lifecycle    <= lk_r.lifecycle;
      out_r.out_exchange     <= lk_r.exchange;
      out_r.out_exchange_ref <= lk_r.exchange_ref;
      out_r.out_filled       <= lk_r.filled;
      out_r.out_remaining    <= lk_r.remaining;
      out_r.out_updated_at   <= lk_r.updated_at;
      out_r.exchange_open    <= ost_pkg::exch_in_range(in_r.exchange_num) ?
                                per_r[in_r.exchange_num] : '0;
      out_r.total_open       <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      cmp_en_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      chg_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int i = 0; i < ost_pkg::TableDepth; i++) valid_r[i] <= 1'b0;
      for (int i = 0; i < ost_pkg::NumExch; i++) per_r[i] <= '0;
    end else begin
      cmp_en_r    <= cmd.scan;
      out_valid_r <= cmd.report;
      if (cmd.capture) begin
        scan_r <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end
      if (cmd.scan) begin
        scan_r <= scan_r + 1'b1;
        if (!valid_r[scan_r]) free_r <= 1'b1;
      end
      if (match) hit_r <= 1'b1;
      if (cmd.exec) begin
        chg_en_r <= chg_en_nxt;
        if (wr_key) valid_r[wr_idx] <= 1'b1;
        if (clr_valid) valid_r[hit_idx_r] <= 1'b0;
      end
      if (cmd.count && chg_en_r) begin
        if (chg_up_r) begin
          total_r <= total_r + 1'b1;
          if (ost_pkg::exch_in_range(chg_exch_r))
            per_r[chg_exch_r] <= per_r[chg_exch_r] + 1'b1;
        end else begin
          if (total_r != '0) total_r <= total_r - 1'b1;
          if (ost_pkg::exch_in_range(chg_exch_r) && per_r[chg_exch_r] != '0)
            per_r[chg_exch_r] <= per_r[chg_exch_r] - 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CntW'(ost_pkg::TableDepth)) else $error("open total beyond table depth");
  a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && wr_key |-> !valid_r[wr_idx]) else $error("insert into used slot");

endmodule

// File: sv/order_state_table.sv
// Channel | ports                     | accepted when
// input   | start, busy, in_item      | start high and busy low
// result  | out_valid, out_item       | out_valid high, one cycle only
// Each item runs a full key search, which reads one entry of the key
// memory per cycle.
// busy stays high from acceptance until the result strobe rises and drops
// as it rises, so the next item can be taken in the result cycle.
// Synchronous active-low reset clears valid bits and open counters at once.
// The receiver cannot stall; every result is shown for one cycle.
module order_state_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ost_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ost_pkg::out_item_t out_item
);

  ost_pkg::ost_cmd_t cmd;
  ost_pkg::ost_sts_t sts;

  ost_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ost_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: tb/tb_order_state_table.sv
module tb_order_state_table;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ost_pkg::in_item_t in_item = '0;
  logic out_valid;
  ost_pkg::out_item_t out_item;

  order_state_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted table contents
  logic          tbl_valid [ost_pkg::TableDepth];
  logic [63:0]   tbl_key   [ost_pkg::TableDepth];
  ost_pkg::rec_t tbl_rec   [ost_pkg::TableDepth];
  int unsigned   exch_cnt  [ost_pkg::NumExch];
  int unsigned   tot_cnt;

  ost_pkg::out_item_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int got = 0;
  int gap_pct = 0;
  logic [63:0] key_pool[$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int find_rec(logic [63:0] k);
    for (int i = 0; i < ost_pkg::TableDepth; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void bump_open(logic [3:0] x, bit up);
    if (up) begin
      tot_cnt++;
      if (x < ost_pkg::NumExch) exch_cnt[x]++;
    end else begin
      if (tot_cnt > 0) tot_cnt--;
      if (x < ost_pkg::NumExch && exch_cnt[x] > 0) exch_cnt[x]--;
    end
  endfunction

  function automatic ost_pkg::out_item_t predict_table(ost_pkg::in_item_t it);
    ost_pkg::out_item_t r;
    int idx;
    int slot;
    bit was;
    bit open_after;
    r = '0;
    r.status = ost_pkg::ST_OK;
    idx = find_rec(it.order_key);
    case (it.req_type)
      ost_pkg::REQ_INSERT: begin
        if (idx >= 0) r.status = ost_pkg::ST_DUP;
        else begin
          slot = -1;
          for (int i = 0; i < ost_pkg::TableDepth; i++)
            if (!tbl_valid[i]) begin slot = i; break; end
          if (slot < 0) r.status = ost_pkg::ST_FULL;
          else begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot] = it.order_key;
            tbl_rec[slot] = '{it.lifecycle_code, it.exchange_num, it.exchange_ref,
                              it.filled_amount, it.remaining_amount, it.time_ns};
            if (it.lifecycle_code <= 3'd2) bump_open(it.exchange_num, 1'b1);
          end
        end
      end
      ost_pkg::REQ_UPDATE: begin
        if (idx < 0) r.status = ost_pkg::ST_MISSING;
        else begin
          was = tbl_rec[idx].lifecycle <= 3'd2;
          open_after = it.lifecycle_code <= 3'd2;
          if (was && !open_after) bump_open(tbl_rec[idx].exchange, 1'b0);
          else if (!was && open_after) bump_open(tbl_rec[idx].exchange, 1'b1);
          tbl_rec[idx].lifecycle = it.lifecycle_code;
          if (it.exchange_ref != 64'd0) tbl_rec[idx].exchange_ref = it.exchange_ref;
          tbl_rec[idx].filled = it.filled_amount;
          tbl_rec[idx].remaining = it.remaining_amount;
          tbl_rec[idx].updated_at = it.time_ns;
        end
      end
      ost_pkg::REQ_REMOVE: begin
        if (idx < 0) r.status = ost_pkg::ST_MISSING;
        else begin
          if (tbl_rec[idx].lifecycle <= 3'd2) bump_open(tbl_rec[idx].exchange, 1'b0);
          tbl_valid[idx] = 1'b0;
        end
      end
      ost_pkg::REQ_LOOKUP: begin
        if (idx < 0) r.status = ost_pkg::ST_MISSING;
        else begin
          r.out_lifecycle = tbl_rec[idx].lifecycle;
          r.out_exchange = tbl_rec[idx].exchange;
          r.out_exchange_ref = tbl_rec[idx].exchange_ref;
          r.out_filled = tbl_rec[idx].filled;
          r.out_remaining = tbl_rec[idx].remaining;
          r.out_updated_at = tbl_rec[idx].updated_at;
        end
      end
      default: ;
    endcase
    r.exchange_open = (it.exchange_num < ost_pkg::NumExch) ?
                      exch_cnt[it.exchange_num][8:0] : 9'd0;
    r.total_open = tot_cnt[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ost_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      got++;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item.status); errors++; end
        if (out_item.out_lifecycle !== e.out_lifecycle) begin
          $error("out_lifecycle exp %0d got %0d", e.out_lifecycle, out_item.out_lifecycle);
          errors++; end
        if (out_item.out_exchange !== e.out_exchange) begin
          $error("out_exchange exp %0d got %0d", e.out_exchange, out_item.out_exchange);
          errors++; end
        if (out_item.out_exchange_ref !== e.out_exchange_ref) begin
          $error("out_exchange_ref exp %h got %h", e.out_exchange_ref,
                 out_item.out_exchange_ref); errors++; end
        if (out_item.out_filled !== e.out_filled) begin
          $error("out_filled exp %h got %h", e.out_filled, out_item.out_filled); errors++; end
        if (out_item.out_remaining !== e.out_remaining) begin
          $error("out_remaining exp %h got %h", e.out_remaining, out_item.out_remaining);
          errors++; end
        if (out_item.out_updated_at !== e.out_updated_at) begin
          $error("out_updated_at exp %h got %h", e.out_updated_at, out_item.out_updated_at);
          errors++; end
        if (out_item.exchange_open !== e.exchange_open) begin
          $error("exchange_open exp %0d got %0d", e.exchange_open, out_item.exchange_open);
          errors++; end
        if (out_item.total_open !== e.total_open) begin
          $error("total_open exp %0d got %0d", e.total_open, out_item.total_open); errors++; end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(ost_pkg::in_item_t it);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_table(it));
    sent++;
    start <= 1'b0;
    if (it.req_type == ost_pkg::REQ_INSERT) key_pool.push_back(it.order_key);
    // start is dropped before the next edge, so the item is not accepted twice
    @(posedge clk);
  endtask

  function automatic ost_pkg::in_item_t mk(logic [2:0] rq, logic [63:0] k, logic [2:0] lc,
                                           logic [3:0] x);
    ost_pkg::in_item_t it;
    it.req_type = rq;
    it.order_key = k;
    it.lifecycle_code = lc;
    it.exchange_num = x;
    it.exchange_ref = rand64();
    it.filled_amount = rand64();
    it.remaining_amount = rand64();
    it.time_ns = rand64();
    return it;
  endfunction

  task automatic test_directed();
    ost_pkg::in_item_t it;
    send_item(mk(ost_pkg::REQ_LOOKUP, 64'd0, 3'd0, 4'd0));
    it = mk(ost_pkg::REQ_INSERT, 64'd0, 3'd0, 4'd0);
    it.exchange_ref = '0; it.filled_amount = '0; it.remaining_amount = '0; it.time_ns = '0;
    send_item(it);
    it = mk(ost_pkg::REQ_INSERT, '1, 3'd7, 4'd15);
    it.exchange_ref = '1; it.filled_amount = '1; it.remaining_amount = '1; it.time_ns = '1;
    send_item(it);
    send_item(mk(ost_pkg::REQ_INSERT, 64'd0, 3'd2, 4'd3));
    send_item(mk(ost_pkg::REQ_LOOKUP, '1, 3'd0, 4'd15));
    send_item(mk(ost_pkg::REQ_UPDATE, '1, 3'd1, 4'd15));
    it = mk(ost_pkg::REQ_UPDATE, '1, 3'd5, 4'd15);
    it.exchange_ref = '0;
    send_item(it);
    send_item(mk(ost_pkg::REQ_LOOKUP, '1, 3'd0, 4'd15));
    send_item(mk(ost_pkg::REQ_UPDATE, 64'h1234, 3'd1, 4'd2));
    send_item(mk(ost_pkg::REQ_REMOVE, 64'h1234, 3'd1, 4'd2));
    send_item(mk(ost_pkg::REQ_COUNT, 64'd5, 3'd0, 4'd0));
    send_item(mk(3'd5, 64'd0, 3'd0, 4'd0));
    send_item(mk(3'd7, '1, 3'd7, 4'd15));
    send_item(mk(ost_pkg::REQ_REMOVE, 64'd0, 3'd0, 4'd0));
    send_item(mk(ost_pkg::REQ_REMOVE, '1, 3'd0, 4'd15));
    send_item(mk(ost_pkg::REQ_LOOKUP, 64'd0, 3'd0, 4'd0));
  endtask

  // fills the table to overflow, then removes every entry of the fill; one further entry inserted midway stays
  task automatic test_full_table();
    for (int i = 0; i < ost_pkg::TableDepth + 2; i++)
      send_item(mk(ost_pkg::REQ_INSERT, 64'h1000 + i, 3'($urandom_range(7)),
                   4'($urandom_range(15))));
    send_item(mk(ost_pkg::REQ_LOOKUP, 64'h1000 + 7, 3'd0, 4'd3));
    for (int i = 0; i < ost_pkg::TableDepth; i += 2)
      send_item(mk(ost_pkg::REQ_REMOVE, 64'h1000 + i, 3'd0, 4'($urandom_range(15))));
    send_item(mk(ost_pkg::REQ_INSERT, 64'h9999, 3'd1, 4'd9));
    for (int i = 1; i < ost_pkg::TableDepth; i += 2)
      send_item(mk(ost_pkg::REQ_REMOVE, 64'h1000 + i, 3'd0, 4'($urandom_range(15))));
  endtask

  task automatic test_random(int n);
    ost_pkg::in_item_t it;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      if (key_pool.size() > 0 && $urandom_range(99) < 75)
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      else if ($urandom_range(3) == 0) k = rand64();
      else k = 64'($urandom_range(40));
      it = mk(3'($urandom_range(99) < 94 ? $urandom_range(4) : $urandom_range(7)), k,
              3'($urandom_range(7)), 4'($urandom_range(15)));
      if ($urandom_range(4) == 0) it.exchange_ref = '0;
      send_item(it);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
  endtask

  initial begin
    for (int i = 0; i < ost_pkg::TableDepth; i++) begin
      tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_rec[i] = '0;
    end
    for (int i = 0; i < ost_pkg::NumExch; i++) exch_cnt[i] = 0;
    tot_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 26;
    test_directed();
    test_full_table();
    test_random(330);
    gap_pct = 70;
    test_random(330);
    gap_pct = 0;
    test_random(330);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d requests, checked %0d results: all request kinds,", sent, got);
    $display("duplicate, missing key, full table and unused codes.");
    if (errors == 0 && expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
